### hdl/spq_pkg.sv
// Shared constants and types for the sorted priority queue.
// No dependencies.
package spq_pkg;

    localparam int FUNC_W   = 1;
    localparam int PRIO_W   = 16;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int DEF_CAPACITY      = 16;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_PAYLOAD_BITS  = 32;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

### hdl/sorted_priority_queue_core.sv
// Sorted priority queue top level: row of spq_cell slots, count and result register.
// Depends on spq_pkg and spq_cell.
//
// Takes one insert or remove per clock cycle; each operation yields one result,
// registered in the output register. All CAPACITY slots compare against the new
// priority in parallel and shift one place left or right in the same cycle,
// whatever the fill level. Input is taken whenever the output register is empty
// or its result is being transferred.
// Equal priorities leave in arrival order.
module sorted_priority_queue_core #(
    parameter int CAPACITY      = spq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = spq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [spq_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [spq_pkg::PAY_W-1:0]           i_payload,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [spq_pkg::STATUS_W-1:0]        o_status,
    output logic [spq_pkg::PAY_W-1:0]           o_removed_payload,
    output logic                                o_removed_valid,
    output logic [spq_pkg::COUNT_W-1:0]         o_count,
    output logic [spq_pkg::PAY_W-1:0]           o_top_payload,
    output logic                                o_top_valid
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                            w_accept;
    logic                            w_full, w_empty;
    spq_pkg::t_cell_ctrl             w_ctrl;
    logic signed [PRIORITY_BITS-1:0] w_new_prio;
    logic        [PAYLOAD_BITS-1:0]  w_new_pay;

    logic                            w_shift [CAPACITY];
    logic                            w_valid [CAPACITY];
    logic signed [PRIORITY_BITS-1:0] w_prio  [CAPACITY];
    logic        [PAYLOAD_BITS-1:0]  w_pay   [CAPACITY];
    logic                            w_nvalid[CAPACITY];
    logic        [PAYLOAD_BITS-1:0]  w_npay  [CAPACITY];

    logic [CNT_W-1:0]                r_count, n_count;
    logic                            r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]    r_status, n_status;
    logic [spq_pkg::PAY_W-1:0]       r_rem_pay, n_rem_pay;
    logic                            r_rem_valid, n_rem_valid;
    logic [spq_pkg::COUNT_W-1:0]     r_count_out;
    logic [spq_pkg::PAY_W-1:0]       r_top_pay, n_top_pay;
    logic                            r_top_valid;

    assign o_ready    = !r_out_valid || i_ready;
    assign w_accept   = i_valid && o_ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_new_prio = PRIORITY_BITS'(i_priority_req);
    assign w_new_pay  = PAYLOAD_BITS'(i_payload);

    assign w_ctrl = '{
        ins: w_accept && (i_func == spq_pkg::FUNC_INSERT) && !w_full,
        rem: w_accept && (i_func == spq_pkg::FUNC_REMOVE) && !w_empty
    };

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                            l_shift, l_valid, nb_valid;
            logic signed [PRIORITY_BITS-1:0] l_prio, nb_prio;
            logic        [PAYLOAD_BITS-1:0]  l_pay, nb_pay;

            if (g == 0) begin : g_first
                assign l_shift = 1'b0;
                assign l_valid = 1'b0;
                assign l_prio  = '0;
                assign l_pay   = '0;
            end else begin : g_mid
                assign l_shift = w_shift[g-1];
                assign l_valid = w_valid[g-1];
                assign l_prio  = w_prio[g-1];
                assign l_pay   = w_pay[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign nb_valid = 1'b0;
                assign nb_prio  = '0;
                assign nb_pay   = '0;
            end else begin : g_inner
                assign nb_valid = w_valid[g+1];
                assign nb_prio  = w_prio[g+1];
                assign nb_pay   = w_pay[g+1];
            end

            spq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS),
                .PAYLOAD_BITS  (PAYLOAD_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_new_prio    (w_new_prio),
                .i_new_pay     (w_new_pay),
                .i_left_shift  (l_shift),
                .i_left_valid  (l_valid),
                .i_left_prio   (l_prio),
                .i_left_pay    (l_pay),
                .i_right_valid (nb_valid),
                .i_right_prio  (nb_prio),
                .i_right_pay   (nb_pay),
                .o_shift       (w_shift[g]),
                .o_valid       (w_valid[g]),
                .o_prio        (w_prio[g]),
                .o_pay         (w_pay[g]),
                .o_next_valid  (w_nvalid[g]),
                .o_next_pay    (w_npay[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = spq_pkg::ST_OK;
        n_rem_pay   = '0;
        n_rem_valid = 1'b0;
        if (i_func == spq_pkg::FUNC_INSERT) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_count     = r_count - CNT_W'(1);
                n_rem_pay   = spq_pkg::PAY_W'(w_pay[0]);
                n_rem_valid = 1'b1;
            end
        end
        n_top_pay = w_nvalid[0] ? spq_pkg::PAY_W'(w_npay[0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_rem_pay   <= n_rem_pay;
            r_rem_valid <= n_rem_valid;
            r_count_out <= spq_pkg::COUNT_W'(n_count);
            r_top_pay   <= n_top_pay;
            r_top_valid <= w_nvalid[0];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_removed_payload = r_rem_pay;
    assign o_removed_valid   = r_rem_valid;
    assign o_count           = r_count_out;
    assign o_top_payload     = r_top_pay;
    assign o_top_valid       = r_top_valid;

endmodule

### hdl/spq_cell.sv
// One slot of the sorted shift-register queue.
// Depends on spq_pkg.
module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
    parameter int PAYLOAD_BITS  = spq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spq_pkg::t_cell_ctrl             i_ctrl,
    input  logic signed [PRIORITY_BITS-1:0] i_new_prio,
    input  logic        [PAYLOAD_BITS-1:0]  i_new_pay,
    input  logic                            i_left_shift,
    input  logic                            i_left_valid,
    input  logic signed [PRIORITY_BITS-1:0] i_left_prio,
    input  logic        [PAYLOAD_BITS-1:0]  i_left_pay,
    input  logic                            i_right_valid,
    input  logic signed [PRIORITY_BITS-1:0] i_right_prio,
    input  logic        [PAYLOAD_BITS-1:0]  i_right_pay,
    output logic                            o_shift,
    output logic                            o_valid,
    output logic signed [PRIORITY_BITS-1:0] o_prio,
    output logic        [PAYLOAD_BITS-1:0]  o_pay,
    output logic                            o_next_valid,
    output logic        [PAYLOAD_BITS-1:0]  o_next_pay
);

    logic                            r_valid, n_valid;
    logic signed [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic        [PAYLOAD_BITS-1:0]  r_pay, n_pay;
    logic                            w_shift;

    // Slot moves right on insert when empty or strictly lower priority (FIFO on ties).
    assign w_shift = !r_valid || (r_prio < i_new_prio);

    always_comb begin
        n_valid = r_valid;
        n_prio  = r_prio;
        n_pay   = r_pay;
        if (i_ctrl.ins && w_shift) begin
            if (i_left_shift) begin
                n_valid = i_left_valid;
                n_prio  = i_left_prio;
                n_pay   = i_left_pay;
            end else begin
                n_valid = 1'b1;
                n_prio  = i_new_prio;
                n_pay   = i_new_pay;
            end
        end else if (i_ctrl.rem) begin
            n_valid = i_right_valid;
            n_prio  = i_right_prio;
            n_pay   = i_right_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_pay  <= n_pay;
    end

    assign o_shift      = w_shift;
    assign o_valid      = r_valid;
    assign o_prio       = r_prio;
    assign o_pay        = r_pay;
    assign o_next_valid = n_valid;
    assign o_next_pay   = n_pay;

endmodule

### dv/tb_top.sv
// Testbench for sorted_priority_queue_core: directed fill/drain and empty/full cases,
// then random insert/remove traffic under four sender/receiver idling mixes.
// Depends on spq_pkg and the RTL of sorted_priority_queue_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = spq_pkg::DEF_CAPACITY;

    typedef struct packed {
        logic [spq_pkg::STATUS_W-1:0] status;
        logic [spq_pkg::PAY_W-1:0]    removed_payload;
        logic                         removed_valid;
        logic [spq_pkg::COUNT_W-1:0]  count;
        logic [spq_pkg::PAY_W-1:0]    top_payload;
        logic                         top_valid;
    } t_queue_result;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [spq_pkg::FUNC_W-1:0]        i_func;
    logic signed [spq_pkg::PRIO_W-1:0] i_priority_req;
    logic [spq_pkg::PAY_W-1:0]         i_payload;
    logic                              o_valid;
    logic                              i_ready;
    logic [spq_pkg::STATUS_W-1:0]      o_status;
    logic [spq_pkg::PAY_W-1:0]         o_removed_payload;
    logic                              o_removed_valid;
    logic [spq_pkg::COUNT_W-1:0]       o_count;
    logic [spq_pkg::PAY_W-1:0]         o_top_payload;
    logic                              o_top_valid;

    logic signed [spq_pkg::PRIO_W-1:0] held_prio [DEPTH];
    logic [spq_pkg::PAY_W-1:0]         held_pay [DEPTH];
    int                                held_count = 0;
    t_queue_result                     pending_results [$];
    int                                fail_count = 0;
    int                                sender_idle_pct = 0;
    int                                receiver_stall_pct = 0;

    sorted_priority_queue_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_priority_req    (i_priority_req),
        .i_payload         (i_payload),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_removed_payload (o_removed_payload),
        .o_removed_valid   (o_removed_valid),
        .o_count           (o_count),
        .o_top_payload     (o_top_payload),
        .o_top_valid       (o_top_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("sorted_priority_queue_core: mismatch");
        $finish;
    end

    // sorted-list predictor: ties go behind all equal-or-higher entries
    task automatic queue_apply(input logic [spq_pkg::FUNC_W-1:0] op,
                               input logic signed [spq_pkg::PRIO_W-1:0] prio,
                               input logic [spq_pkg::PAY_W-1:0] pay);
        t_queue_result r;
        int pos;
        r = '0;
        r.status = spq_pkg::ST_OK;
        if (op == spq_pkg::FUNC_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held_prio[pos] >= prio) pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_prio[i] = held_prio[i-1];
                    held_pay[i]  = held_pay[i-1];
                end
                held_prio[pos] = prio;
                held_pay[pos]  = pay;
                held_count++;
            end
        end else begin
            if (held_count == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                r.removed_payload = held_pay[0];
                r.removed_valid   = 1'b1;
                for (int i = 1; i < held_count; i++) begin
                    held_prio[i-1] = held_prio[i];
                    held_pay[i-1]  = held_pay[i];
                end
                held_count--;
            end
        end
        r.count = spq_pkg::COUNT_W'(held_count);
        if (held_count > 0) begin
            r.top_payload = held_pay[0];
            r.top_valid   = 1'b1;
        end
        pending_results.push_back(r);
    endtask

    // input transfer predicted first, so the oldest expectation is always at the front
    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) queue_apply(i_func, i_priority_req, i_payload);
            if (o_valid && i_ready) begin
                got = '{o_status, o_removed_payload, o_removed_valid, o_count,
                        o_top_payload, o_top_valid};
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with nothing pending: status %0d count %0d",
                                 $realtime, got.status, got.count);
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status ||
                        got.removed_payload != want.removed_payload ||
                        got.removed_valid != want.removed_valid ||
                        got.count != want.count ||
                        got.top_payload != want.top_payload ||
                        got.top_valid != want.top_valid) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: exp st=%0d rem=%h/%b cnt=%0d top=%h/%b",
                                     $realtime, want.status, want.removed_payload,
                                     want.removed_valid, want.count, want.top_payload,
                                     want.top_valid);
                            $display("%0t: act st=%0d rem=%h/%b cnt=%0d top=%h/%b",
                                     $realtime, got.status, got.removed_payload,
                                     got.removed_valid, got.count, got.top_payload,
                                     got.top_valid);
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send_op(input logic [spq_pkg::FUNC_W-1:0] op,
                           input logic [spq_pkg::PRIO_W-1:0] prio,
                           input logic [spq_pkg::PAY_W-1:0] pay);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= op;
        i_priority_req <= prio;
        i_payload      <= pay;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_remove_empty();
        send_op(spq_pkg::FUNC_REMOVE, 16'sh1234, 32'hDEAD_BEEF);
    endtask

    // extremes, ties at several levels, then one insert past capacity
    task automatic test_fill_to_full();
        send_op(spq_pkg::FUNC_INSERT, 16'sh7FFF, 32'hFFFF_FFFF);
        send_op(spq_pkg::FUNC_INSERT, 16'sh8000, 32'h0000_0000);
        send_op(spq_pkg::FUNC_INSERT, 16'sh0000, 32'hAAAA_AAAA);
        send_op(spq_pkg::FUNC_INSERT, 16'sh0000, 32'h5555_5555);
        send_op(spq_pkg::FUNC_INSERT, 16'sh0000, 32'h0000_0001);
        send_op(spq_pkg::FUNC_INSERT, 16'shFFFF, 32'h0000_0002);
        send_op(spq_pkg::FUNC_INSERT, 16'sh7FFF, 32'h0000_0003);
        send_op(spq_pkg::FUNC_INSERT, 16'sh8000, 32'h0000_0004);
        for (int i = 0; i < 8; i++)
            send_op(spq_pkg::FUNC_INSERT,
                    (i < 3) ? 16'sd5 : (i < 5) ? -16'sd5 : 16'sd1, 32'h100 + i);
        send_op(spq_pkg::FUNC_INSERT, 16'sh7FFF, 32'hCAFE_F00D);
    endtask

    task automatic test_drain_front();
        for (int i = 0; i < 4; i++)
            send_op(spq_pkg::FUNC_REMOVE, spq_pkg::PRIO_W'($urandom), $urandom);
    endtask

    // bursts biased toward insert or remove so the fill level sweeps empty to full
    task automatic test_random_mix(input int n_ops);
        int insert_pct;
        int pick;
        logic [spq_pkg::PRIO_W-1:0] prio;
        insert_pct = 50;
        for (int k = 0; k < n_ops; k++) begin
            if (k % 24 == 0) begin
                pick = $urandom_range(2);
                insert_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
            end
            pick = $urandom_range(9);
            if (pick == 0)
                prio = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            else if (pick <= 3)
                prio = spq_pkg::PRIO_W'($urandom);
            else
                prio = spq_pkg::PRIO_W'(int'($urandom_range(6)) - 3);
            send_op(($urandom_range(99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                      : spq_pkg::FUNC_REMOVE,
                    prio, $urandom);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = spq_pkg::FUNC_INSERT;
        i_priority_req = '0;
        i_payload      = '0;
        i_ready        = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_remove_empty();
        test_fill_to_full();
        test_drain_front();
        test_random_mix(450);
        wait_drained();

        sender_idle_pct = 55;
        test_random_mix(450);
        wait_drained();

        sender_idle_pct    = 0;
        receiver_stall_pct = 55;
        test_random_mix(450);
        wait_drained();

        sender_idle_pct    = 29;
        receiver_stall_pct = 29;
        test_random_mix(450);
        wait_drained();

        if (fail_count == 0)
            $display("sorted_priority_queue_core: match");
        else
            $display("sorted_priority_queue_core: mismatch");
        $finish;
    end

endmodule
